// File: hw/rtl/dspalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dspalu_pkg;

  localparam int DATA_DEPTH_DEF = 256;
  localparam int COEF_DEPTH_DEF = 256;

  // Commands; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_COEF_WR = 2'd1,
    CMD_START   = 2'd2
  } cmd_t;

  // Operand sources (instr_word[10:6])
  localparam logic [4:0] SRC_ACC    = 5'h10;
  localparam logic [4:0] SRC_TEMP_A = 5'h19;
  localparam logic [4:0] SRC_TEMP_B = 5'h1a;
  localparam logic [4:0] SRC_RAM    = 5'h07;

  // Destinations (instr_word[4:0])
  localparam logic [4:0] DST_TEMP_A = 5'h13;
  localparam logic [4:0] DST_TEMP_B = 5'h14;
  localparam logic [4:0] DST_RAM    = 5'h07;

  // Class field (instr_word[23:20])
  localparam logic [3:0] CLASS_MAC  = 4'ha;
  localparam logic [2:0] CLASS_STEP = 3'h2;

  localparam int SPILL_BIT = 28;

  localparam logic [23:0] SAT_MAX = 24'h7fffff;
  localparam logic [23:0] SAT_MIN = 24'h800000;

  // One write request into a store
  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    logic [23:0] data;
  } wr_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/dspalu_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dspalu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [39:0]        instr_word;
  logic [7:0]         coef_addr;
  logic [23:0]        coef_value;
  logic signed [23:0] sample;

  modport source (output valid, cmd, instr_word, coef_addr, coef_value, sample,
                  input ready);
  modport sink (input valid, cmd, instr_word, coef_addr, coef_value, sample,
                output ready);
endinterface

interface dspalu_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] datum;
  logic               bad_source;

  modport source (output valid, datum, bad_source, input ready);
  modport sink (input valid, datum, bad_source, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dspalu_store.sv
`timescale 1ns / 1ps
`default_nettype none

// 24-bit store, one write and one read port, registered read.
// Entries read as zero until written; same-address write forwards.
module dspalu_store
  import dspalu_pkg::*;
#(
  parameter int DEPTH = DATA_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire wr_req_t     wr,
  input  wire logic [7:0]  raddr,
  output logic      [23:0] rdata
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int Recip = 65536 / DEPTH;

  // 8-bit address modulo DEPTH: reciprocal multiply, one correction step
  function automatic logic [IdxW-1:0] wrap_idx(input logic [7:0] a);
    logic [20:0] prod;
    logic [16:0] back;
    logic [16:0] diff;
    prod = 21'(a) * 21'(Recip);
    back = 17'(prod[20:16]) * 17'(DEPTH);
    diff = 17'(a) - back;
    if (diff >= 17'(DEPTH)) begin
      diff = diff - 17'(DEPTH);
    end
    return diff[IdxW-1:0];
  endfunction

  logic [23:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [IdxW-1:0]  widx;
  logic [IdxW-1:0]  ridx;
  logic [23:0]      mem_q;
  logic             rvalid;
  logic             byp;
  logic [23:0]      byp_data;

  assign widx = wrap_idx(wr.addr);
  assign ridx = wrap_idx(raddr);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[widx] <= wr.data;
    end
    mem_q    <= mem[ridx];
    byp_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
      byp    <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[widx] <= 1'b1;
      end
      rvalid <= valid[ridx];
      byp    <= wr.we && (widx == ridx);
    end
  end

  assign rdata = byp ? byp_data : (rvalid ? mem_q : 24'd0);

endmodule

`default_nettype wire

// File: hw/rtl/dspalu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

// Decode and datapath: operand select, accumulate, multiply, pointers.
module dspalu_exec
  import dspalu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic [1:0]         cmd,
  input  wire logic [39:0]        instr_word,
  input  wire logic [7:0]         coef_addr,
  input  wire logic [23:0]        coef_value,
  input  wire logic signed [23:0] sample,
  input  wire logic [23:0]        data_rd,
  input  wire logic [23:0]        coef_rd,
  output wr_req_t                 data_wr,
  output wr_req_t                 coef_wr,
  output logic [7:0]              data_raddr,
  output logic [7:0]              coef_raddr,
  output logic [23:0]             datum_next,
  output logic                    bad_source
);

  function automatic logic [23:0] sat_datum(input logic [43:0] a);
    logic [27:0] v;
    v = a[43:16];
    if (!v[27] && (|v[26:23])) begin
      return SAT_MAX;
    end else if (v[27] && !(&v[26:23])) begin
      return SAT_MIN;
    end
    return v[23:0];
  endfunction

  logic [43:0] acc, acc_next;
  logic [23:0] acc_datum;
  logic [43:0] product, product_next;
  logic [23:0] temp_a, temp_a_next;
  logic [23:0] temp_b, temp_b_next;
  logic [7:0]  pointer, pointer_next;
  logic [7:0]  cursor, cursor_next;

  logic        spill;
  logic [3:0]  cls;
  logic [7:0]  step;
  logic [4:0]  src;
  logic [4:0]  dst;
  logic        src_ok;
  logic [23:0] lbits;
  logic signed [47:0] mul;
  logic [43:0] acc_sum;

  assign spill = instr_word[SPILL_BIT];
  assign cls   = instr_word[23:20];
  assign step  = instr_word[19:12];
  assign src   = instr_word[10:6];
  assign dst   = instr_word[4:0];

  always_comb begin
    src_ok = 1'b1;
    unique case (src)
      SRC_ACC:    lbits = acc_datum;
      SRC_TEMP_A: lbits = temp_a;
      SRC_TEMP_B: lbits = {temp_b[23], temp_b[23:1]};
      SRC_RAM:    lbits = data_rd;
      default: begin
        lbits  = 24'd0;
        src_ok = 1'b0;
      end
    endcase
  end

  assign mul     = $signed(coef_rd) * $signed(lbits);
  assign acc_sum = (spill ? 44'd0 : acc) + product;

  always_comb begin
    acc_next     = acc;
    datum_next   = acc_datum;
    product_next = product;
    temp_a_next  = temp_a;
    temp_b_next  = temp_b;
    pointer_next = pointer;
    cursor_next  = cursor;
    data_wr      = '0;
    coef_wr      = '0;
    bad_source   = 1'b0;
    if (fire) begin
      unique case (cmd)
        CMD_EXEC: begin
          if (src_ok) begin
            acc_next     = acc_sum;
            datum_next   = sat_datum(acc_sum);
            // product >> 6, sign-extended to 44 bits
            product_next = (cls == CLASS_MAC) ? {{2{mul[47]}}, mul[47:6]} : 44'd0;
            if (dst == DST_TEMP_A) begin
              temp_a_next = lbits;
            end
            if (dst == DST_TEMP_B) begin
              temp_b_next = lbits;
            end
            data_wr.we   = spill || (dst == DST_RAM);
            data_wr.addr = pointer;
            data_wr.data = (dst == DST_RAM) ? lbits : acc_datum;
            if (cls == CLASS_MAC) begin
              cursor_next = cursor + 8'd1;
            end
            if (cls[2:0] == CLASS_STEP) begin
              pointer_next = pointer + step;
            end
          end else begin
            bad_source = 1'b1;
          end
        end
        CMD_COEF_WR: begin
          coef_wr.we   = 1'b1;
          coef_wr.addr = coef_addr;
          coef_wr.data = coef_value;
        end
        CMD_START: begin
          acc_next     = {{4{sample[23]}}, sample, 16'd0};
          datum_next   = sample;
          pointer_next = 8'd0;
          cursor_next  = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // stores prefetch the entries the next item will see
  assign data_raddr = pointer_next;
  assign coef_raddr = cursor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_datum <= '0;
      product   <= '0;
      temp_a    <= '0;
      temp_b    <= '0;
      pointer   <= '0;
      cursor    <= '0;
    end else begin
      acc       <= acc_next;
      acc_datum <= datum_next;
      product   <= product_next;
      temp_a    <= temp_a_next;
      temp_b    <= temp_b_next;
      pointer   <= pointer_next;
      cursor    <= cursor_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dsp_alu_instruction_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                          Accepted when
// in_ch     in   cmd, instr_word, coef_addr, coef_value, sample   valid && ready
// out_ch    out  datum, bad_source                                valid && ready
//
// One item per cycle unless out_ch stalls; one registered result per item.
// Data RAM and coefficient RAM are read ahead (registered) at the pointer and
// cursor values the next item will use; a write to the same entry forwards.
// Reset: per-entry valid bits clear both RAMs at once (no sweep).
// in_ch.ready follows out_ch: a new item enters whenever the result register
// is empty or being taken in the same cycle.
module dsp_alu_instruction_step
  import dspalu_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int COEF_DEPTH = COEF_DEPTH_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  dspalu_in_if.sink      in_ch,
  dspalu_out_if.source   out_ch
);

  logic        fire;
  wr_req_t     data_wr;
  wr_req_t     coef_wr;
  logic [7:0]  data_raddr;
  logic [7:0]  coef_raddr;
  logic [23:0] data_rd;
  logic [23:0] coef_rd;
  logic [23:0] datum_next;
  logic        bad_next;

  // result register
  logic        out_valid;
  logic [23:0] out_datum;
  logic        out_bad;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  dspalu_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (in_ch.cmd),
    .instr_word (in_ch.instr_word),
    .coef_addr  (in_ch.coef_addr),
    .coef_value (in_ch.coef_value),
    .sample     (in_ch.sample),
    .data_rd    (data_rd),
    .coef_rd    (coef_rd),
    .data_wr    (data_wr),
    .coef_wr    (coef_wr),
    .data_raddr (data_raddr),
    .coef_raddr (coef_raddr),
    .datum_next (datum_next),
    .bad_source (bad_next)
  );

  // data RAM: spill / store at the pointer
  dspalu_store #(.DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (data_wr),
    .raddr (data_raddr),
    .rdata (data_rd)
  );

  // coefficient RAM: written by coefficient commands, read at the cursor
  dspalu_store #(.DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (coef_wr),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_datum <= datum_next;
      out_bad   <= bad_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.datum      = out_datum;
  assign out_ch.bad_source = out_bad;

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // every accepted item leaves a result
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted item produced no result");

  // only execute can flag a bad source
  a_bad_exec: assert property (@(posedge clk) disable iff (rst)
    fire && (in_ch.cmd != CMD_EXEC) |=> !out_bad)
    else $error("bad_source on non-execute item");

  // start sample reports the sample itself
  a_start_datum: assert property (@(posedge clk) disable iff (rst)
    fire && (in_ch.cmd == CMD_START) |=> out_datum == $past(in_ch.sample))
    else $error("start sample datum mismatch");

  // data RAM writes only come from accepted execute items
  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    data_wr.we |-> fire && (in_ch.cmd == CMD_EXEC))
    else $error("data RAM write without execute item");

endmodule

`default_nettype wire
